// ===== sv/vn_pkg.sv =====
`default_nettype none
package vn_pkg;
  localparam int unsigned DefComponentWidth = 16;
  localparam int unsigned UnitWidth = 16;
  localparam int unsigned QuotWidth = UnitWidth - 1;
  localparam int unsigned FracShift = 2 * QuotWidth;
endpackage
`default_nettype wire

// ===== sv/vn_if.sv =====
`default_nettype none
interface vn_in_if #(
  parameter int unsigned ComponentWidth = vn_pkg::DefComponentWidth
);
  logic                             valid;
  logic                             ready;
  logic signed [ComponentWidth-1:0] x_in;
  logic signed [ComponentWidth-1:0] y_in;
  logic signed [ComponentWidth-1:0] z_in;
  modport source (output valid, x_in, y_in, z_in, input ready);
  modport sink (input valid, x_in, y_in, z_in, output ready);
endinterface

interface vn_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vn_pkg::UnitWidth-1:0] x_unit;
  logic signed [vn_pkg::UnitWidth-1:0] y_unit;
  logic signed [vn_pkg::UnitWidth-1:0] z_unit;
  logic                               zero_vector;
  modport source (output valid, x_unit, y_unit, z_unit, zero_vector, input ready);
  modport sink (input valid, x_unit, y_unit, z_unit, zero_vector, output ready);
endinterface
`default_nettype wire

// ===== sv/vn_square.sv =====
`default_nettype none
module vn_square #(
  parameter int unsigned ComponentWidth = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [ComponentWidth-1:0]     raw_i,
  output logic      [2*ComponentWidth-1:0]   sq_o,
  output logic                               neg_o
);
  logic [ComponentWidth-1:0]   mag;
  logic [2*ComponentWidth-1:0] sq_q;
  logic                        neg_q;

  // two's complement magnitude, most negative value maps to 2^(w-1)
  assign mag = raw_i[ComponentWidth-1] ? (~raw_i + 1'b1) : raw_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= mag * mag;
      neg_q <= raw_i[ComponentWidth-1];
    end
  end

  assign sq_o  = sq_q;
  assign neg_o = neg_q;
endmodule
`default_nettype wire

// ===== sv/vn_step.sv =====
`default_nettype none
module vn_step
  import vn_pkg::*;
#(
  parameter int unsigned ComponentWidth = 16,
  parameter int unsigned Bit = 0
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   en_i,
  input  wire logic [2*ComponentWidth+FracShift-1:0]  r_i,
  input  wire logic [2*ComponentWidth+QuotWidth-1:0]  t_i,
  input  wire logic [2*ComponentWidth-1:0]            s_i,
  input  wire logic [QuotWidth-1:0]                   q_i,
  input  wire logic                                   neg_i,
  output logic      [2*ComponentWidth+FracShift-1:0]  r_o,
  output logic      [2*ComponentWidth+QuotWidth-1:0]  t_o,
  output logic      [2*ComponentWidth-1:0]            s_o,
  output logic      [QuotWidth-1:0]                   q_o,
  output logic                                        neg_o
);
  localparam int unsigned SW = 2 * ComponentWidth;
  localparam int unsigned RW = SW + FracShift;
  localparam int unsigned TW = SW + QuotWidth;
  localparam int unsigned CW = SW + FracShift + 1;

  logic [CW-1:0] trial;
  logic [CW-1:0] r_ext;
  logic          take;
  logic [RW-1:0] r_d, r_q;
  logic [TW-1:0] t_d, t_q;
  logic [SW-1:0] s_q;
  logic [QuotWidth-1:0] q_d, q_q;
  logic          neg_q;

  // cand^2*s - q^2*s = 2^(b+1)*q*s + 2^(2b)*s, with t holding q*s
  always_comb begin
    trial = (CW'(t_i) << (Bit + 1)) + (CW'(s_i) << (2 * Bit));
    r_ext = CW'(r_i);
    take  = (trial <= r_ext);
    r_d   = take ? RW'(r_ext - trial) : r_i;
    t_d   = take ? (t_i + (TW'(s_i) << Bit)) : t_i;
    q_d   = q_i | (QuotWidth'(take) << Bit);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q   <= r_d;
      t_q   <= t_d;
      s_q   <= s_i;
      q_q   <= q_d;
      neg_q <= neg_i;
    end
  end

  assign r_o   = r_q;
  assign t_o   = t_q;
  assign s_o   = s_q;
  assign q_o   = q_q;
  assign neg_o = neg_q;
endmodule
`default_nettype wire

// ===== sv/vn_lane.sv =====
`default_nettype none
module vn_lane
  import vn_pkg::*;
#(
  parameter int unsigned ComponentWidth = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [2*ComponentWidth-1:0]   sq_i,
  input  wire logic [2*ComponentWidth-1:0]   s_i,
  input  wire logic                          neg_i,
  output logic      [QuotWidth-1:0]          q_o,
  output logic                               neg_o
);
  localparam int unsigned SW = 2 * ComponentWidth;
  localparam int unsigned RW = SW + FracShift;
  localparam int unsigned TW = SW + QuotWidth;

  logic [RW-1:0]        r   [QuotWidth+1];
  logic [TW-1:0]        t   [QuotWidth+1];
  logic [SW-1:0]        s   [QuotWidth+1];
  logic [QuotWidth-1:0] q   [QuotWidth+1];
  logic                 neg [QuotWidth+1];

  // residual starts at mag^2 * 2^30
  assign r[0]   = RW'(sq_i) << FracShift;
  assign t[0]   = '0;
  assign s[0]   = s_i;
  assign q[0]   = '0;
  assign neg[0] = neg_i;

  for (genvar k = 0; k < QuotWidth; k++) begin : g_step
    vn_step #(
      .ComponentWidth(ComponentWidth),
      .Bit           (QuotWidth - 1 - k)
    ) u_step (
      .clk_i,
      .en_i,
      .r_i  (r[k]),
      .t_i  (t[k]),
      .s_i  (s[k]),
      .q_i  (q[k]),
      .neg_i(neg[k]),
      .r_o  (r[k+1]),
      .t_o  (t[k+1]),
      .s_o  (s[k+1]),
      .q_o  (q[k+1]),
      .neg_o(neg[k+1])
    );
  end

  assign q_o   = q[QuotWidth];
  assign neg_o = neg[QuotWidth];
endmodule
`default_nettype wire

// ===== sv/vector3_normalize.sv =====
// vector3_normalize: unit vector of a signed three-component vector
//
// in_i carries one vector (x_in, y_in, z_in) per transaction, all of one scale.
// out_o carries the Q1.15 unit vector, truncated toward zero and saturated to
// +/-32767, plus zero_vector, which is set with all-zero units for a zero input.
//
// a result passes in order through the registers of the pipeline stages
// (capture, square, sum, 15 root/divide steps, output register).
// throughput: one transaction per cycle unless stalled; each lane resolves one
// quotient bit per pipeline stage, so the 15-step chain sets the depth, not the rate.
//
// the whole pipeline advances together; when out_o is valid and not taken,
// every stage holds and in_i.ready drops; bubbles in front of a waiting result
// are not squeezed out, so no new transaction is taken until the output
// transaction completes.
//
// reset clears all valid bits; no results are pending afterwards.
`default_nettype none
module vector3_normalize
  import vn_pkg::*;
#(
  parameter int unsigned ComponentWidth = DefComponentWidth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vn_in_if.sink     in_i,
  vn_out_if.source  out_o
);
  localparam int unsigned SW = 2 * ComponentWidth;

  logic en;

  // stall only when a finished result is waiting
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // ---- capture stage
  logic [ComponentWidth-1:0] raw_q [3];
  logic                      va_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      raw_q[0] <= in_i.x_in;
      raw_q[1] <= in_i.y_in;
      raw_q[2] <= in_i.z_in;
    end
  end

  // ---- square stage, one multiplier per lane
  logic [SW-1:0] sq   [3];
  logic          negb [3];

  for (genvar i = 0; i < 3; i++) begin : g_sq
    vn_square #(.ComponentWidth(ComponentWidth)) u_sq (
      .clk_i,
      .en_i (en),
      .raw_i(raw_q[i]),
      .sq_o (sq[i]),
      .neg_o(negb[i])
    );
  end

  // ---- merge stage: sum of squares shared by all lanes
  logic [SW-1:0] sum_q;
  logic [SW-1:0] sqc_q  [3];
  logic          negc_q [3];
  logic          zeroc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q   <= sq[0] + sq[1] + sq[2];
      zeroc_q <= (sq[0] == '0) && (sq[1] == '0) && (sq[2] == '0);
      for (int i = 0; i < 3; i++) begin
        sqc_q[i]  <= sq[i];
        negc_q[i] <= negb[i];
      end
    end
  end

  // ---- root/divide lanes
  logic [QuotWidth-1:0] q   [3];
  logic                 neg [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vn_lane #(.ComponentWidth(ComponentWidth)) u_lane (
      .clk_i,
      .en_i (en),
      .sq_i (sqc_q[i]),
      .s_i  (sum_q),
      .neg_i(negc_q[i]),
      .q_o  (q[i]),
      .neg_o(neg[i])
    );
  end

  // valid and zero flag travel beside the lanes
  logic                 vb_q, vc_q;
  logic [QuotWidth-1:0] vstep_q;
  logic [QuotWidth-1:0] zstep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      vstep_q <= '0;
    end else if (en) begin
      va_q    <= in_i.valid;
      vb_q    <= va_q;
      vc_q    <= vb_q;
      vstep_q <= {vstep_q[QuotWidth-2:0], vc_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zstep_q <= {zstep_q[QuotWidth-2:0], zeroc_q};
    end
  end

  // ---- output register: sign restore and zero forcing
  logic [UnitWidth-1:0] unit_d [3];
  logic [UnitWidth-1:0] unit_q [3];
  logic                 zero_q;
  logic                 vout_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (zstep_q[QuotWidth-1]) begin
        unit_d[i] = '0;
      end else if (neg[i]) begin
        unit_d[i] = UnitWidth'(-{1'b0, q[i]});
      end else begin
        unit_d[i] = {1'b0, q[i]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      unit_q <= unit_d;
      zero_q <= zstep_q[QuotWidth-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en) begin
      vout_q <= vstep_q[QuotWidth-1];
    end
  end

  assign out_o.valid       = vout_q;
  assign out_o.x_unit      = unit_q[0];
  assign out_o.y_unit      = unit_q[1];
  assign out_o.z_unit      = unit_q[2];
  assign out_o.zero_vector = zero_q;

  // zero flag forces all units to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_vector |->
      out_o.x_unit == '0 && out_o.y_unit == '0 && out_o.z_unit == '0)
    else $error("zero vector with nonzero units");

  // saturation keeps the most negative code out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.x_unit != 16'h8000 && out_o.y_unit != 16'h8000
      && out_o.z_unit != 16'h8000)
    else $error("unit component out of range");

  // input is held off only by a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("pipeline stalled without back pressure");
endmodule
`default_nettype wire

// ===== verif/vector3_normalize_checker.sv =====
module vector3_normalize_checker
  import vn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  vn_in_if.sink       in_mon,
  vn_out_if.sink      out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [UnitWidth-1:0] x_unit;
    logic signed [UnitWidth-1:0] y_unit;
    logic signed [UnitWidth-1:0] z_unit;
    logic                        zero_vector;
  } unit_vec_t;

  unit_vec_t   unit_q[$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = unit_q.size();

  // largest q <= 32767 with q*q*sum <= mag*mag*2^30
  function automatic logic [UnitWidth-1:0] unit_component(logic signed [15:0] c,
                                                          logic [63:0] sum);
    logic [16:0]  mag;
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [14:0]  q;
    logic [14:0]  cand;
    mag = (c < 0) ? 17'(-$signed(17'(c))) : 17'(c);
    rhs = 128'(mag) * 128'(mag) << FracShift;
    q = '0;
    for (int b = QuotWidth - 1; b >= 0; b--) begin
      cand = q | (15'd1 << b);
      lhs  = 128'(cand) * 128'(cand) * 128'(sum);
      if (lhs <= rhs) q = cand;
    end
    return (c < 0) ? UnitWidth'(-$signed({1'b0, q})) : UnitWidth'(q);
  endfunction

  function automatic unit_vec_t normalize(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] z);
    unit_vec_t   r;
    logic [63:0] sum;
    sum = 64'(longint'(x) * x + longint'(y) * y + longint'(z) * z);
    if (sum == 0) begin
      r = '{x_unit: '0, y_unit: '0, z_unit: '0, zero_vector: 1'b1};
    end else begin
      r.x_unit      = unit_component(x, sum);
      r.y_unit      = unit_component(y, sum);
      r.z_unit      = unit_component(z, sum);
      r.zero_vector = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    unit_vec_t e;
    if (!rst_ni) begin
      fails = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        unit_q.push_back(normalize(in_mon.x_in, in_mon.y_in, in_mon.z_in));
      if (out_mon.valid && out_mon.ready) begin
        if (unit_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fails++;
        end else begin
          e = unit_q.pop_front();
          if (out_mon.x_unit !== e.x_unit) begin
            $error("x_unit expected %0d actual %0d", e.x_unit, out_mon.x_unit);
            fails++;
          end
          if (out_mon.y_unit !== e.y_unit) begin
            $error("y_unit expected %0d actual %0d", e.y_unit, out_mon.y_unit);
            fails++;
          end
          if (out_mon.z_unit !== e.z_unit) begin
            $error("z_unit expected %0d actual %0d", e.z_unit, out_mon.z_unit);
            fails++;
          end
          if (out_mon.zero_vector !== e.zero_vector) begin
            $error("zero_vector expected %0b actual %0b", e.zero_vector,
                   out_mon.zero_vector);
            fails++;
          end
        end
      end
    end
  end
endmodule

// ===== verif/vector3_normalize_test.sv =====
module vector3_normalize_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom   = 1030;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vn_in_if  in_ch ();
  vn_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  bit          stim_done;
  bit          calm;        // no idling on either side
  bit          hold_off;    // long receiver stall

  typedef logic signed [15:0] comp_t;
  comp_t dir_x[$];
  comp_t dir_y[$];
  comp_t dir_z[$];

  vector3_normalize i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  vector3_normalize_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch.sink),
    .out_mon     (out_ch.sink),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.x_in   = '0;
    in_ch.y_in   = '0;
    in_ch.z_in   = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // random component with bias toward extremes and small values
  function automatic comp_t rand_comp();
    case ($urandom_range(0, 9))
      0: return comp_t'(16'h8000);
      1: return comp_t'(16'h7fff);
      2: return comp_t'(int'($urandom_range(0, 8)) - 4);
      3: return '0;
      default: return comp_t'($urandom());
    endcase
  endfunction

  // directed corner vectors
  task automatic add_dir(input comp_t x, input comp_t y, input comp_t z);
    dir_x.push_back(x);
    dir_y.push_back(y);
    dir_z.push_back(z);
  endtask

  // receiver: random stalls, with a calm stretch and one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else if (calm) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 99) >= 18);
  end

  initial begin
    hold_off = 1'b0;
    wait (rst_ni);
    repeat (300) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (80) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // sender
  initial begin
    int unsigned total;
    comp_t       vx;
    comp_t       vy;
    comp_t       vz;
    stim_done = 1'b0;
    calm      = 1'b0;
    add_dir(0, 0, 0);
    add_dir(16'sh7fff, 0, 0);
    add_dir(16'sh8000, 0, 0);
    add_dir(0, 16'sh7fff, 0);
    add_dir(0, 16'sh8000, 0);
    add_dir(0, 0, 16'sh7fff);
    add_dir(0, 0, 16'sh8000);
    add_dir(1, 0, 0);
    add_dir(0, -1, 0);
    add_dir(0, 0, 1);
    add_dir(16'sh8000, 16'sh8000, 16'sh8000);
    add_dir(16'sh7fff, 16'sh7fff, 16'sh7fff);
    add_dir(16'sh8000, 16'sh7fff, 16'sh8000);
    add_dir(1, 1, 1);
    add_dir(-1, -1, -1);
    add_dir(3, 4, 0);
    add_dir(-3, 0, 4);
    add_dir(16'sh5555, 16'shaaaa, 16'sh1234);
    add_dir(1, 16'sh8000, 0);
    add_dir(16'shffff, 16'sh7fff, 1);
    total = dir_x.size() + NumRandom;
    wait (rst_ni);
    @(posedge clk_i);
    for (int unsigned n = 0; n < total; n++) begin
      if (n == 400) calm = 1'b1;
      if (n == 600) calm = 1'b0;
      if (n < dir_x.size()) begin
        vx = dir_x[n];
        vy = dir_y[n];
        vz = dir_z[n];
      end else begin
        vx = rand_comp();
        vy = rand_comp();
        vz = rand_comp();
      end
      while (!calm && $urandom_range(0, 99) < 18) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
      in_ch.valid <= 1'b1;
      in_ch.x_in  <= vx;
      in_ch.y_in  <= vy;
      in_ch.z_in  <= vz;
      do @(posedge clk_i); while (!in_ch.ready);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    wait (rst_ni);
    fork
      begin
        wait (stim_done && pending == 0);
        repeat (DrainCycles) @(posedge clk_i);
      end
      begin
        wait (idle_cycles >= IdleLimit);
        $display("FAILURE");
        $finish;
      end
    join_any
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
